// ----- design/dvfs_pkg.sv -----
`default_nettype none
package dvfs_pkg;

    localparam int MAX_SLOTS = 16;

    localparam logic [1:0] KIND_BEGIN = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    localparam logic [1:0] REG_MAX_FREQ    = 2'd0;
    localparam logic [1:0] REG_MIN_FREQ    = 2'd1;
    localparam logic [1:0] REG_ENABLE_WALL = 2'd2;
    localparam logic [1:0] REG_DISABLE_WALL = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  slot;
        logic [31:0] elapsed_us;
        logic [4:0]  thread_count;
        logic [31:0] wall_us;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  out_slot;
        logic [15:0] plan_mhz;
        logic        planning_active;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [15:0] hi_mhz;
        logic [15:0] lo_mhz;
        logic [31:0] en_wall;
        logic [31:0] dis_wall;
    } cfg_t;

endpackage
`default_nettype wire

// ----- design/dvfs_cmd_queue.sv -----
`default_nettype none
module dvfs_cmd_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire dvfs_pkg::in_item_t push_item,
    output logic                    full,
    input  wire logic               pop,
    output dvfs_pkg::in_item_t      head,
    output logic                    empty
);
    import dvfs_pkg::*;

    in_item_t   mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

// ----- design/dvfs_divider.sv -----
`default_nettype none
// Restoring divider: 64-bit dividend by 48-bit divisor, one quotient bit a cycle.
// Only quotients up to 16 bits matter, so the quotient saturates at 17 bits.
module dvfs_divider (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [47:0] divisor,
    output logic             done,
    output logic [16:0]      quotient
);
    logic [63:0] rem_reg;
    logic [63:0] rem_next;
    logic [47:0] div_reg;
    logic [16:0] quo_reg;
    logic [16:0] quo_next;
    logic [5:0]  step_reg;
    logic        busy_reg;
    logic        done_reg;
    logic        sat_reg;
    logic [111:0] shifted;
    logic        fits;

    // The quotient fits in 17 bits when the dividend's upper part is below the divisor.
    always_comb
    begin
        shifted  = {48'd0, rem_reg} >> step_reg;
        fits     = (shifted >= {64'd0, div_reg});
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (fits)
        begin
            rem_next = rem_reg - ({16'd0, div_reg} << step_reg);
        end
        quo_next = {quo_reg[15:0], fits};
    end

    assign done     = done_reg;
    assign quotient = sat_reg ? 17'h1FFFF : quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 6'd0;
            rem_reg  <= 64'd0;
            div_reg  <= 48'd0;
            quo_reg  <= 17'd0;
            sat_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                rem_reg  <= dividend;
                div_reg  <= divisor;
                quo_reg  <= 17'd0;
                step_reg <= 6'd16;
                sat_reg  <= (dividend[63:17] >= {15'd0, divisor}) ? 1'b1 : 1'b0;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                if (step_reg == 6'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg - 6'd1;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ----- design/dvfs_engine.sv -----
`default_nettype none
module dvfs_engine (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dvfs_pkg::cfg_t     cfg,
    input  wire logic               empty,
    input  wire dvfs_pkg::in_item_t head,
    output logic                    pop,
    output logic                    idle,
    output logic                    res_valid,
    output dvfs_pkg::out_item_t     res
);
    import dvfs_pkg::*;

    localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW = $clog2(MAX_SLOTS + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_END, S_SCAN, S_MUL, S_DIV, S_WAIT, S_EMIT
    } state_t;

    state_t state_reg;

    logic [31:0] pend_mem [MAX_SLOTS];
    logic [31:0] hel_mem  [MAX_SLOTS];
    logic [15:0] htg_mem  [MAX_SLOTS];
    logic [15:0] ptg_mem  [MAX_SLOTS];
    logic [MAX_SLOTS-1:0] pend_ok_reg;
    logic [MAX_SLOTS-1:0] hist_ok_reg;
    logic [MAX_SLOTS-1:0] ptg_ok_reg;

    logic [CW-1:0] hist_len_reg;
    logic          seen_reg;
    logic          plan_on_reg;
    in_item_t      item_reg;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] lim_reg;
    logic [SW:0]   idx_reg;
    logic [47:0]   max_work_reg;
    logic [47:0]   work_reg;
    logic          plan_reg;
    logic [15:0]   tgt_reg;
    logic          div_start_reg;

    logic [SW-1:0] ix;
    logic [31:0]   hel_rd;
    logic [15:0]   htg_rd;
    logic [15:0]   ptg_rd;
    logic [31:0]   pend_rd;
    logic [15:0]   eff_t;
    logic [47:0]   work_now;
    logic [SW-1:0] done_slot;
    logic [32:0]   acc_sum;
    logic [4:0]    raw_cnt;
    logic [CW-1:0] sat_cnt;
    logic          div_done;
    logic [16:0]   quo;
    logic [16:0]   clamped;

    assign ix      = idx_reg[SW-1:0];
    assign hel_rd  = hist_ok_reg[ix] ? hel_mem[ix] : 32'd0;
    assign htg_rd  = hist_ok_reg[ix] ? htg_mem[ix] : 16'd0;
    assign ptg_rd  = ptg_ok_reg[ix] ? ptg_mem[ix] : 16'd4800;
    assign pend_rd = pend_ok_reg[ix] ? pend_mem[ix] : 32'd0;
    assign eff_t   = (htg_rd != 16'd0) ? htg_rd : cfg.hi_mhz;
    assign work_now = {16'd0, hel_rd} * {32'd0, eff_t};
    assign done_slot = head.slot[SW-1:0];
    assign acc_sum  = {1'b0, (pend_ok_reg[done_slot] ? pend_mem[done_slot] : 32'd0)}
                      + {1'b0, head.elapsed_us};
    assign raw_cnt  = head.thread_count;
    assign sat_cnt  = ({27'd0, raw_cnt} > MAX_SLOTS) ? CW'(MAX_SLOTS) : CW'(raw_cnt);

    dvfs_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend ({16'd0, cfg.hi_mhz} * {16'd0, work_reg}),
        .divisor  (max_work_reg),
        .done     (div_done),
        .quotient (quo)
    );

    assign clamped = (quo > {1'b0, cfg.hi_mhz}) ? {1'b0, cfg.hi_mhz} :
                     (quo < {1'b0, cfg.lo_mhz}) ? {1'b0, cfg.lo_mhz} : quo;

    assign pop  = (state_reg == S_IDLE) && !empty;
    assign idle = (state_reg == S_IDLE) && empty;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && !empty && head.kind == KIND_DONE
            && {28'd0, head.slot} < MAX_SLOTS)
        begin
            pend_mem[done_slot] <= acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
        end
        if (state_reg == S_END && {1'b0, idx_reg} < {1'b0, cnt_reg})
        begin
            hel_mem[ix] <= pend_rd;
            htg_mem[ix] <= ptg_rd;
        end
        if (state_reg == S_EMIT)
        begin
            ptg_mem[ix] <= tgt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pend_ok_reg   <= '0;
            hist_ok_reg   <= '0;
            ptg_ok_reg    <= '0;
            hist_len_reg  <= '0;
            seen_reg      <= 1'b0;
            plan_on_reg   <= 1'b0;
            item_reg      <= '0;
            cnt_reg       <= '0;
            lim_reg       <= '0;
            idx_reg       <= '0;
            max_work_reg  <= '0;
            work_reg      <= '0;
            plan_reg      <= 1'b0;
            tgt_reg       <= '0;
            div_start_reg <= 1'b0;
            res_valid     <= 1'b0;
            res           <= '0;
        end
        else
        begin
            res_valid     <= 1'b0;
            div_start_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (!empty)
                    begin
                        item_reg <= head;
                        idx_reg  <= '0;
                        cnt_reg  <= sat_cnt;
                        case (head.kind)
                            KIND_DONE:
                            begin
                                if ({28'd0, head.slot} < MAX_SLOTS)
                                begin
                                    pend_ok_reg[done_slot] <= 1'b1;
                                end
                            end
                            KIND_END:
                            begin
                                state_reg <= S_END;
                            end
                            KIND_BEGIN:
                            begin
                                if (sat_cnt == '0)
                                begin
                                    cnt_reg <= CW'(1);
                                end
                                lim_reg <= ((sat_cnt == '0 ? CW'(1) : sat_cnt) < hist_len_reg)
                                           ? (sat_cnt == '0 ? CW'(1) : sat_cnt) : hist_len_reg;
                                plan_reg     <= plan_on_reg && seen_reg && (hist_len_reg != '0);
                                max_work_reg <= '0;
                                state_reg    <= S_SCAN;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_END:
                begin
                    // One slot a cycle: history takes pending time and planned target for the team, pending clears.
                    if ({1'b0, idx_reg} < {1'b0, cnt_reg})
                    begin
                        hist_ok_reg[ix] <= 1'b1;
                    end
                    pend_ok_reg[ix] <= 1'b0;
                    if (idx_reg == (SW+1)'(MAX_SLOTS - 1))
                    begin
                        hist_len_reg <= cnt_reg;
                        if (!plan_on_reg && item_reg.wall_us >= cfg.en_wall)
                        begin
                            plan_on_reg <= 1'b1;
                        end
                        else if (plan_on_reg && item_reg.wall_us <= cfg.dis_wall)
                        begin
                            plan_on_reg <= 1'b0;
                        end
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_SCAN:
                begin
                    if (!plan_reg || {1'b0, idx_reg} >= {1'b0, lim_reg})
                    begin
                        if (max_work_reg == '0)
                        begin
                            plan_reg <= 1'b0;
                        end
                        idx_reg   <= '0;
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        if (work_now > max_work_reg)
                        begin
                            max_work_reg <= work_now;
                        end
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_MUL:
                begin
                    if (plan_reg && {1'b0, idx_reg} < {1'b0, lim_reg})
                    begin
                        work_reg      <= work_now;
                        div_start_reg <= 1'b1;
                        state_reg     <= S_WAIT;
                    end
                    else
                    begin
                        tgt_reg   <= cfg.hi_mhz;
                        state_reg <= S_EMIT;
                    end
                end
                S_WAIT:
                begin
                    if (div_done)
                    begin
                        tgt_reg   <= clamped[15:0];
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    ptg_ok_reg[ix] <= 1'b1;
                    if ({1'b0, idx_reg} < {1'b0, cnt_reg})
                    begin
                        res_valid           <= 1'b1;
                        res.out_slot        <= 4'(idx_reg);
                        res.plan_mhz        <= tgt_reg;
                        res.planning_active <= plan_on_reg;
                        res.last            <= ({1'b0, idx_reg} + 1'b1 == {1'b0, cnt_reg});
                    end
                    if (idx_reg == (SW+1)'(MAX_SLOTS - 1))
                    begin
                        seen_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_MUL;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- design/dvfs_work_balance_planner_core.sv -----
`default_nettype none
// Channel | Direction | Handshake
// item    | in        | start && !busy, payload on item
// result  | out       | strobe high one cycle, payload on result
// config  | in        | APB write at psel && penable && pwrite, paddr[1:0] == 0
// A beat is written into the queue when accepted and leaves it once the engine is idle.
// A thread-done beat only adds to its slot's pending time; a region-end beat walks all
// MAX_SLOTS slots, one a cycle. A begin beat scans the planned history for the largest
// work, then walks every slot: S_MUL to S_EMIT at max, via S_WAIT and the 17-step
// divider for a planned slot. Reset is asynchronous. The receiver cannot stall; busy
// is high only while the two-entry queue is full.
module dvfs_work_balance_planner_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire dvfs_pkg::in_item_t  item,
    output logic                     strobe,
    output dvfs_pkg::out_item_t      result,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [3:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);
    import dvfs_pkg::*;

    logic [15:0] max_reg;
    logic [15:0] min_reg;
    logic [31:0] en_reg;
    logic [31:0] dis_reg;
    cfg_t        cfg;
    logic        full;
    logic        empty;
    logic        pop;
    logic        idle;
    in_item_t    head;

    assign pready = 1'b1;
    assign busy   = full;

    assign cfg.hi_mhz   = (max_reg >= min_reg) ? max_reg : min_reg;
    assign cfg.lo_mhz   = (max_reg >= min_reg) ? min_reg : max_reg;
    assign cfg.en_wall  = (en_reg >= dis_reg) ? en_reg : dis_reg;
    assign cfg.dis_wall = (en_reg >= dis_reg) ? dis_reg : en_reg;

    always_comb
    begin
        case (paddr[3:2])
            REG_MAX_FREQ:     prdata = {16'd0, max_reg};
            REG_MIN_FREQ:     prdata = {16'd0, min_reg};
            REG_ENABLE_WALL:  prdata = en_reg;
            REG_DISABLE_WALL: prdata = dis_reg;
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg <= 16'd4800;
            min_reg <= 16'd800;
            en_reg  <= 32'd1200;
            dis_reg <= 32'd800;
        end
        else if (psel && penable && pwrite && paddr[1:0] == 2'd0)
        begin
            case (paddr[3:2])
                REG_MAX_FREQ:     max_reg <= pwdata[15:0];
                REG_MIN_FREQ:     min_reg <= pwdata[15:0];
                REG_ENABLE_WALL:  en_reg  <= pwdata;
                REG_DISABLE_WALL: dis_reg <= pwdata;
                default:          ;
            endcase
        end
    end

    dvfs_cmd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (start && !full),
        .push_item (item),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    dvfs_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .empty     (empty),
        .head      (head),
        .pop       (pop),
        .idle      (idle),
        .res_valid (strobe),
        .res       (result)
    );

    logic unused_idle;
    assign unused_idle = idle;
endmodule
`default_nettype wire

// ----- test/dvfs_planner_checker.sv -----
module dvfs_planner_checker (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic                busy,
    input  wire dvfs_pkg::in_item_t  item,
    input  wire logic                strobe,
    input  wire dvfs_pkg::out_item_t result,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [3:0]          paddr,
    input  wire logic [31:0]         pwdata,
    input  wire logic                pready,
    output int                       mismatch_count,
    output int                       targets_waiting
);
    timeunit 1ns;
    timeprecision 1ps;
    import dvfs_pkg::*;

    localparam int SLOTS = 16;

    logic [15:0] max_mhz, min_mhz;
    logic [31:0] en_wall, dis_wall;
    logic [31:0] pending [SLOTS];
    logic [31:0] hist_elapsed [SLOTS];
    logic [15:0] hist_target [SLOTS];
    logic [15:0] planned [SLOTS];
    logic [4:0]  hist_len;
    logic        seen, planning;
    out_item_t   target_queue [$];

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    task automatic plan_item(input in_item_t it);
        logic [15:0] hi, lo;
        logic [31:0] en, dis, sum;
        logic [63:0] work, peak;
        logic [79:0] q;
        int cnt, lim;
        logic plan;
        out_item_t r;
        hi = (max_mhz >= min_mhz) ? max_mhz : min_mhz;
        lo = (max_mhz >= min_mhz) ? min_mhz : max_mhz;
        cnt = (it.thread_count > SLOTS) ? SLOTS : int'(it.thread_count);
        case (it.kind)
            KIND_DONE:
            begin
                sum = pending[it.slot] + it.elapsed_us;
                pending[it.slot] = (sum < it.elapsed_us) ? 32'hFFFF_FFFF : sum;
            end
            KIND_END:
            begin
                en = (en_wall >= dis_wall) ? en_wall : dis_wall;
                dis = (en_wall >= dis_wall) ? dis_wall : en_wall;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (i < cnt)
                    begin
                        hist_elapsed[i] = pending[i];
                        hist_target[i] = planned[i];
                    end
                    pending[i] = '0;
                end
                hist_len = 5'(cnt);
                if (!planning && it.wall_us >= en)
                    planning = 1'b1;
                else if (planning && it.wall_us <= dis)
                    planning = 1'b0;
            end
            KIND_BEGIN:
            begin
                plan = planning && seen && hist_len != 0;
                if (cnt == 0)
                    cnt = 1;
                lim = (cnt < hist_len) ? cnt : int'(hist_len);
                peak = '0;
                if (plan)
                begin
                    for (int i = 0; i < lim; i++)
                    begin
                        work = 64'(hist_elapsed[i])
                            * 64'(hist_target[i] != 0 ? hist_target[i] : hi);
                        if (work > peak)
                            peak = work;
                    end
                    if (peak == 0)
                        plan = 1'b0;
                end
                for (int i = 0; i < SLOTS; i++)
                begin
                    r.plan_mhz = hi;
                    if (plan && i < lim)
                    begin
                        work = 64'(hist_elapsed[i])
                            * 64'(hist_target[i] != 0 ? hist_target[i] : hi);
                        q = (80'(hi) * 80'(work)) / 80'(peak);
                        if (q > hi)
                            q = 80'(hi);
                        if (q < lo)
                            q = 80'(lo);
                        r.plan_mhz = q[15:0];
                    end
                    planned[i] = r.plan_mhz;
                    if (i < cnt)
                    begin
                        r.out_slot = 4'(i);
                        r.planning_active = planning;
                        r.last = (i + 1 == cnt);
                        target_queue.insert(target_queue.size(), r);
                    end
                end
                seen = 1'b1;
            end
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_mhz = 16'd4800;
            min_mhz = 16'd800;
            en_wall = 32'd1200;
            dis_wall = 32'd800;
            for (int i = 0; i < SLOTS; i++)
            begin
                pending[i] = '0;
                hist_elapsed[i] = '0;
                hist_target[i] = '0;
                planned[i] = 16'd4800;
            end
            hist_len = '0;
            seen = 1'b0;
            planning = 1'b0;
            target_queue.delete();
            mismatch_count = 0;
            targets_waiting = 0;
        end
        else
        begin
            // Results are compared before this edge's item is planned, since an
            // accepted beat cannot produce a target in the same cycle.
            if (strobe)
            begin
                if (target_queue.size() == 0)
                    report($sformatf("unexpected target slot %0d", result.out_slot));
                else
                begin
                    out_item_t e;
                    e = target_queue.pop_front();
                    if (result.out_slot !== e.out_slot)
                        report($sformatf("out_slot %0d, expected %0d",
                            result.out_slot, e.out_slot));
                    if (result.plan_mhz !== e.plan_mhz)
                        report($sformatf("slot %0d plan_mhz %0d, expected %0d",
                            e.out_slot, result.plan_mhz, e.plan_mhz));
                    if (result.planning_active !== e.planning_active)
                        report($sformatf("slot %0d planning_active %b, expected %b",
                            e.out_slot, result.planning_active, e.planning_active));
                    if (result.last !== e.last)
                        report($sformatf("slot %0d last %b, expected %b",
                            e.out_slot, result.last, e.last));
                end
            end
            if (psel && penable && pwrite && pready)
                case (paddr[3:2])
                    REG_MAX_FREQ:     max_mhz = pwdata[15:0];
                    REG_MIN_FREQ:     min_mhz = pwdata[15:0];
                    REG_ENABLE_WALL:  en_wall = pwdata;
                    REG_DISABLE_WALL: dis_wall = pwdata;
                    default: ;
                endcase
            if (start && !busy)
                plan_item(item);
            targets_waiting = target_queue.size();
        end
    end
endmodule

// ----- test/dvfs_work_balance_planner_core_tb.sv -----
module dvfs_work_balance_planner_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dvfs_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    in_item_t    item = '0;
    logic        strobe;
    out_item_t   result;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          mismatch_count, targets_waiting;
    int          burst_left = 0;

    always #5 clk = ~clk;

    dvfs_work_balance_planner_core DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .strobe(strobe), .result(result), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    dvfs_planner_checker checker_i (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .strobe(strobe), .result(result), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .pready(pready),
        .mismatch_count(mismatch_count), .targets_waiting(targets_waiting)
    );

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Stops sending, then waits out every expected target and the rest of a begin walk.
    task automatic drain();
        start <= 1'b0;
        while (targets_waiting != 0)
            @(posedge clk);
        repeat (400)
            @(posedge clk);
    endtask

    // Start stays high between beats of a burst and drops only for a gap.
    task automatic send(input in_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap != 0)
            begin
                start <= 1'b0;
                repeat (gap)
                    @(posedge clk);
            end
        end
        burst_left--;
        item <= it;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
    endtask

    function automatic in_item_t make(input logic [1:0] k, input logic [3:0] s,
                                      input logic [31:0] e, input logic [4:0] c,
                                      input logic [31:0] w);
        in_item_t it;
        it.kind = k;
        it.slot = s;
        it.elapsed_us = e;
        it.thread_count = c;
        it.wall_us = w;
        return it;
    endfunction

    function automatic logic [31:0] rand_time();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(1, 5000);
        endcase
    endfunction

    // One region: thread-done beats for the team, maybe a stray thread-done beat, a region end, then a begin.
    task automatic region(input int team, input logic [31:0] wall);
        for (int i = 0; i < team; i++)
            send(make(KIND_DONE, 4'(i), rand_time(), 5'($urandom), $urandom));
        if ($urandom_range(0, 3) == 0)
            send(make(KIND_DONE, 4'($urandom), $urandom, 5'($urandom), $urandom));
        send(make(KIND_END, 4'($urandom), $urandom, 5'(team), wall));
        send(make(KIND_BEGIN, 4'($urandom), $urandom,
            5'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : team), $urandom));
    endtask

    task automatic random_phase(input int items);
        int n;
        logic [31:0] w;
        n = 0;
        while (n < items)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                int team;
                team = $urandom_range(1, 16);
                w = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 3000) : $urandom;
                region(team, w);
                n += team + 2;
            end
            else
            begin
                send(make(2'($urandom), 4'($urandom), $urandom, 5'($urandom), $urandom));
                n++;
            end
        end
    endtask

    initial
    begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: begin before any history, saturated pending time, zero and
        // oversized counts, unknown kind, out-of-range end count.
        send(make(KIND_BEGIN, 4'd0, 32'd0, 5'd0, 32'd0));
        send(make(KIND_DONE, 4'd15, 32'hFFFF_FFFF, 5'd0, 32'd0));
        send(make(KIND_DONE, 4'd15, 32'hFFFF_FFFF, 5'd0, 32'd0));
        send(make(KIND_DONE, 4'd0, 32'd100, 5'd31, 32'hFFFF_FFFF));
        send(make(KIND_DONE, 4'd1, 32'd0, 5'd0, 32'd0));
        send(make(2'd3, 4'd5, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF));
        send(make(KIND_END, 4'd0, 32'd0, 5'd31, 32'hFFFF_FFFF));
        send(make(KIND_BEGIN, 4'd0, 32'd0, 5'd31, 32'd0));
        send(make(KIND_DONE, 4'd0, 32'd50, 5'd0, 32'd0));
        send(make(KIND_DONE, 4'd1, 32'd100, 5'd0, 32'd0));
        send(make(KIND_END, 4'd0, 32'd0, 5'd2, 32'd1200));
        send(make(KIND_BEGIN, 4'd0, 32'd0, 5'd16, 32'd0));
        // Zero largest work, then zero team size and hysteresis off.
        send(make(KIND_END, 4'd0, 32'd0, 5'd3, 32'd900));
        send(make(KIND_BEGIN, 4'd0, 32'd0, 5'd3, 32'd0));
        send(make(KIND_END, 4'd0, 32'd0, 5'd0, 32'd800));
        send(make(KIND_BEGIN, 4'd0, 32'd0, 5'd1, 32'd0));
        random_phase(100);
        drain();

        // Swapped limits and thresholds, including the extremes.
        write_reg(REG_MAX_FREQ, 32'd1);
        write_reg(REG_MIN_FREQ, 32'hFFFF);
        write_reg(REG_ENABLE_WALL, 32'd0);
        write_reg(REG_DISABLE_WALL, 32'hFFFF_FFFF);
        random_phase(110);
        drain();

        write_reg(REG_MAX_FREQ, 32'hFFFF);
        write_reg(REG_MIN_FREQ, 32'd1);
        write_reg(REG_ENABLE_WALL, 32'd2000);
        write_reg(REG_DISABLE_WALL, 32'd100);
        random_phase(110);
        drain();

        write_reg(REG_MAX_FREQ, $urandom_range(1, 65535));
        write_reg(REG_MIN_FREQ, $urandom_range(1, 65535));
        write_reg(REG_ENABLE_WALL, $urandom_range(0, 3000));
        write_reg(REG_DISABLE_WALL, $urandom_range(0, 3000));
        random_phase(110);
        drain();

        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ----- filelist.f -----
design/dvfs_pkg.sv
design/dvfs_cmd_queue.sv
design/dvfs_divider.sv
design/dvfs_engine.sv
design/dvfs_work_balance_planner_core.sv
test/dvfs_planner_checker.sv
test/dvfs_work_balance_planner_core_tb.sv
